[design/putca_pkg.sv]
`default_nettype none
package putca_pkg;

	localparam int NUM_PARAMS = 32;
	localparam int IDX_W      = 5;
	localparam int CNT_W      = 64;
	localparam int INC_W      = 32;
	localparam int IN_W       = 176;
	localparam int OUT_W      = 136;
	localparam int MEM_W      = 2 * CNT_W;

	localparam logic CMD_ACCUM   = 1'b0;
	localparam logic CMD_RECHECK = 1'b1;

	// register index as seen in paddr[2]
	localparam logic REG_ALL_ALERT_INHIBIT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADJ,
		ST_ACC,
		ST_CHK
	} putca_state_t;

	// input word, last field in the lowest bits
	typedef struct packed {
		logic [4:0]       pad;
		logic             monitor_valid;
		logic             end_of_period;
		logic             potential_change;
		logic             ua_declared;
		logic             is_uas_adjusted;
		logic             is_uas;
		logic [CNT_W-1:0] threshold;
		logic [CNT_W-1:0] max_value;
		logic [INC_W-1:0] increment;
		logic [IDX_W-1:0] param_index;
	} item_t;

	typedef struct packed {
		logic [3:0]       pad;
		logic             unfiltered_active;
		logic             alert_active;
		logic             alert_cleared;
		logic             alert_declared;
		logic [CNT_W-1:0] reported_value;
		logic [CNT_W-1:0] count_value;
	} result_t;

	// base + add, never above ceil; a base at or above ceil stays
	function automatic logic [CNT_W-1:0] sat_add(
		input logic [CNT_W-1:0] base,
		input logic [CNT_W-1:0] add,
		input logic [CNT_W-1:0] ceil
	);
		logic [CNT_W:0] sum;
		logic [CNT_W-1:0] res;
		sum = {1'b0, base} + {1'b0, add};
		if (base >= ceil) begin
			res = base;
		end else if (sum > {1'b0, ceil}) begin
			res = ceil;
		end else begin
			res = sum[CNT_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [CNT_W-1:0] floor_sub(
		input logic [CNT_W-1:0] base,
		input logic [CNT_W-1:0] sub
	);
		return (base < sub) ? '0 : base - sub;
	endfunction

endpackage
`default_nettype wire

[design/pm_counter_uas_adjust_tca.sv]
// The input word is captured and its entry memory read at accept; the adjust,
// accumulate and check steps follow, and the write-back and result word register at
// commit. These are serialized: no new word is accepted until the last one commits.
// A result held by the output register blocks only the write-back step.
// Reset: control, alert/unfiltered/availability flags and entry valid bits clear
// at once; counts and adjustments read as zero until an entry is written.
`default_nettype none
module pm_counter_uas_adjust_tca (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	// param_index, increment, max_value, threshold, is_uas, is_uas_adjusted,
	// ua_declared, potential_change, end_of_period, monitor_valid, zero pad
	input  wire [putca_pkg::IN_W-1:0]  s_tdata,
	// cmd
	input  wire                        s_tuser,
	output logic                       m_tvalid,
	input  wire                        m_tready,
	// count_value, reported_value, alert_declared, alert_cleared, alert_active,
	// unfiltered_active, zero pad
	output logic [putca_pkg::OUT_W-1:0] m_tdata,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [2:0]                  paddr,
	input  wire [31:0]                 pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import putca_pkg::*;

	putca_state_t state_q, state_d;

	logic [MEM_W-1:0] mem [NUM_PARAMS];
	logic [MEM_W-1:0] rd_q;
	logic [NUM_PARAMS-1:0] mem_valid_q;
	logic rd_valid_q;

	logic [NUM_PARAMS-1:0] prev_q, alert_q, unf_q;
	logic inhibit_q;

	item_t item_q;
	logic cmd_q;

	logic [CNT_W-1:0] val1_q, addamt_q, val2_q, adj2_q;

	logic m_tvalid_q;
	result_t res_q;

	logic accept, commit, cfg_wr;
	logic [IDX_W-1:0] idx;
	logic [CNT_W-1:0] val0, adj0, maxv, inc_ext, room;
	logic [CNT_W-1:0] val1, addamt, val2, adj2, rep;
	logic acc_upd, uas_any, flip, add_inc;
	logic prev_bit, alert_bit, unf_bit;
	logic new_prev, new_alert, new_unf, declared, cleared, hit;
	result_t res_d;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inhibit_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == REG_ALL_ALERT_INHIBIT) begin
			inhibit_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ALL_ALERT_INHIBIT) begin
			prdata = {31'b0, inhibit_q};
		end
	end

	// handshake
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == ST_CHK) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_ADJ;
			ST_ADJ:  state_d = ST_ACC;
			ST_ACC:  state_d = ST_CHK;
			ST_CHK:  if (commit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// capture item and read its entry; param_index sits in the lowest bits
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_t'(s_tdata);
			cmd_q  <= s_tuser;
			rd_q   <= mem[s_tdata[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else if (accept) begin
			rd_valid_q <= mem_valid_q[s_tdata[IDX_W-1:0]];
		end
	end

	assign idx     = item_q.param_index;
	assign val0    = rd_valid_q ? rd_q[CNT_W-1:0] : '0;
	assign adj0    = rd_valid_q ? rd_q[MEM_W-1:CNT_W] : '0;
	assign maxv    = item_q.max_value;
	assign inc_ext = {{(CNT_W-INC_W){1'b0}}, item_q.increment};

	assign prev_bit  = prev_q[idx];
	assign alert_bit = alert_q[idx];
	assign unf_bit   = unf_q[idx];

	assign acc_upd = (cmd_q == CMD_ACCUM) && !item_q.end_of_period;
	assign uas_any = item_q.is_uas || item_q.is_uas_adjusted;
	assign flip    = (prev_bit != item_q.ua_declared);
	// unavailable-seconds count only while the link is unavailable, adjusted
	// ones only while it is available
	assign add_inc = acc_upd && (!uas_any || (item_q.ua_declared == item_q.is_uas));

	// adjust step: apply pending adjustment on an availability flip
	always_comb begin
		val1 = val0;
		if (acc_upd && uas_any && flip) begin
			if (item_q.ua_declared == item_q.is_uas) begin
				val1 = sat_add(val0, adj0, maxv);
			end else begin
				val1 = floor_sub(val0, adj0);
			end
		end
		room   = (val0 >= maxv) ? '0 : maxv - val0;
		addamt = (inc_ext < room) ? inc_ext : room;
	end

	// accumulate step
	always_comb begin
		val2 = add_inc ? sat_add(val1_q, inc_ext, maxv) : val1_q;
		adj2 = adj0;
		if (acc_upd && uas_any) begin
			if (flip || !item_q.potential_change) begin
				adj2 = '0;
			end else begin
				adj2 = sat_add(adj0, addamt_q, maxv);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADJ) begin
			val1_q   <= val1;
			addamt_q <= addamt;
		end
		if (state_q == ST_ACC) begin
			val2_q <= val2;
			adj2_q <= adj2;
		end
	end

	// check step: reported value, alert flags
	always_comb begin
		if (acc_upd && item_q.potential_change) begin
			rep = '0;
		end else begin
			rep = val2_q;
		end
		hit = (cmd_q == CMD_ACCUM) && item_q.monitor_valid && (item_q.threshold != '0)
			&& (rep >= item_q.threshold) && !inhibit_q;
		new_prev  = (acc_upd && uas_any && flip) ? item_q.ua_declared : prev_bit;
		new_alert = alert_bit;
		new_unf   = unf_bit;
		declared  = 1'b0;
		cleared   = 1'b0;
		if (cmd_q == CMD_RECHECK) begin
			if (val2_q < item_q.threshold) begin
				cleared   = alert_bit || unf_bit;
				new_alert = 1'b0;
				new_unf   = 1'b0;
			end
		end else if (hit && !unf_bit) begin
			new_unf = 1'b1;
			if (!alert_bit) begin
				new_alert = 1'b1;
				declared  = 1'b1;
			end
		end
		res_d                   = '0;
		res_d.count_value       = val2_q;
		res_d.reported_value    = rep;
		res_d.alert_declared    = declared;
		res_d.alert_cleared     = cleared;
		res_d.alert_active      = new_alert;
		res_d.unfiltered_active = new_unf;
	end

	// write-back
	always_ff @(posedge clk) begin
		if (commit) begin
			mem[idx] <= {adj2_q, val2_q};
			res_q    <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_valid_q <= '0;
			prev_q      <= '0;
			alert_q     <= '0;
			unf_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (commit) begin
				mem_valid_q[idx] <= 1'b1;
				prev_q[idx]      <= new_prev;
				alert_q[idx]     <= new_alert;
				unf_q[idx]       <= new_unf;
				m_tvalid_q       <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[design/putca_chk.sv]
`default_nettype none
module putca_chk (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_tvalid,
	input wire                        s_tready,
	input wire                        m_tvalid,
	input wire                        m_tready,
	input wire [putca_pkg::OUT_W-1:0] m_tdata
);
	import putca_pkg::*;

	result_t res;
	assign res = result_t'(m_tdata);

	// a held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// a new alert leaves both flags set
	a_decl_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.alert_declared |-> res.alert_active && res.unfiltered_active)
		else $error("alert declared without flags set");

	// a clear leaves both flags low and declares nothing
	a_clr_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.alert_cleared |->
			!res.alert_active && !res.unfiltered_active && !res.alert_declared)
		else $error("alert cleared with flags still set");

endmodule

bind pm_counter_uas_adjust_tca putca_chk u_putca_chk (.*);
`default_nettype wire

[bench/tb_pm_counter_uas_adjust_tca.sv]
`default_nettype none
module tb_pm_counter_uas_adjust_tca;
	timeunit 1ns;
	timeprecision 1ps;

	import putca_pkg::*;

	// input flag bits for table rows
	localparam logic [5:0] FL_UAS   = 6'b000001;
	localparam logic [5:0] FL_ADJ   = 6'b000010;
	localparam logic [5:0] FL_UA    = 6'b000100;
	localparam logic [5:0] FL_PEND  = 6'b001000;
	localparam logic [5:0] FL_EOP   = 6'b010000;
	localparam logic [5:0] FL_VALID = 6'b100000;
	// result flag bits for table rows
	localparam logic [3:0] RS_DECL = 4'b0001;
	localparam logic [3:0] RS_CLR  = 4'b0010;
	localparam logic [3:0] RS_ACT  = 4'b0100;
	localparam logic [3:0] RS_UNF  = 4'b1000;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int N_PHASES = 6;

	typedef struct {
		logic    cmd;
		item_t   it;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [2:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	// shadow of the counter table
	logic [63:0] cnt_mem [NUM_PARAMS];
	logic [63:0] adj_mem [NUM_PARAMS];
	logic        unavail [NUM_PARAMS];
	logic        alert_f [NUM_PARAMS];
	logic        unfilt_f [NUM_PARAMS];
	logic        inhibit;

	// stimulus bias per entry: parameter kind and link state
	int   ptype [NUM_PARAMS];
	logic link_ua [NUM_PARAMS];

	result_t  reports_due [$];
	dir_row_t dir_rows [$];
	int fails;
	int idle_pct;
	int stall_pct;
	int hold_left;

	int          ph_sidle [N_PHASES] = '{0, 76, 0, 18, 0, 18};
	int          ph_rstall [N_PHASES] = '{0, 0, 76, 18, 0, 18};
	int          ph_items [N_PHASES] = '{400, 300, 400, 300, 300, 300};
	bit          ph_press [N_PHASES] = '{0, 0, 0, 0, 1, 0};
	logic [31:0] ph_cfg [N_PHASES] = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
		32'h1, 32'h0, 32'h2};

	pm_counter_uas_adjust_tca u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("pm_counter_uas_adjust_tca regression: fail");
		$finish;
	end

	function automatic logic [63:0] cap_add(input logic [63:0] base, input logic [63:0] add,
		input logic [63:0] ceil);
		logic [63:0] room;
		if (base >= ceil) begin
			return base;
		end
		room = ceil - base;
		return base + ((add < room) ? add : room);
	endfunction

	// one read-modify-write of the addressed entry
	function automatic result_t update_entry(input item_t it, input logic cmd);
		result_t     r;
		logic [63:0] val;
		logic [63:0] rep;
		logic [63:0] inc;
		logic [63:0] room;
		logic [63:0] grow;
		int          p;
		logic        decl;
		logic        clr;
		r = '0;
		decl = 1'b0;
		clr = 1'b0;
		p = int'(it.param_index);
		inc = {32'h0, it.increment};
		val = cnt_mem[p];
		if (cmd == CMD_RECHECK) begin
			if (val < it.threshold) begin
				if (alert_f[p]) begin
					alert_f[p] = 1'b0;
					clr = 1'b1;
				end
				if (unfilt_f[p]) begin
					unfilt_f[p] = 1'b0;
					clr = 1'b1;
				end
			end
			rep = val;
		end else begin
			if (it.end_of_period) begin
				rep = val;
			end else begin
				if (it.is_uas || it.is_uas_adjusted) begin
					if (unavail[p] != it.ua_declared) begin
						// flip: pending seconds are added on entering the state this kind counts in, taken off on leaving it
						if (it.ua_declared == it.is_uas) begin
							val = cap_add(val, adj_mem[p], it.max_value);
						end else begin
							val = (val < adj_mem[p]) ? 64'h0 : val - adj_mem[p];
						end
						unavail[p] = it.ua_declared;
						adj_mem[p] = '0;
					end else if (it.potential_change) begin
						room = (val >= it.max_value) ? 64'h0 : it.max_value - val;
						grow = (inc < room) ? inc : room;
						adj_mem[p] = cap_add(adj_mem[p], grow, it.max_value);
					end else begin
						adj_mem[p] = '0;
					end
					if (it.ua_declared == it.is_uas) begin
						val = cap_add(val, inc, it.max_value);
					end
				end else begin
					val = cap_add(val, inc, it.max_value);
				end
				cnt_mem[p] = val;
				rep = it.potential_change ? 64'h0 : val;
			end
			if (it.monitor_valid && it.threshold != 0 && rep >= it.threshold && !inhibit
				&& !unfilt_f[p]) begin
				unfilt_f[p] = 1'b1;
				if (!alert_f[p]) begin
					alert_f[p] = 1'b1;
					decl = 1'b1;
				end
			end
		end
		r.count_value = cnt_mem[p];
		r.reported_value = rep;
		r.alert_declared = decl;
		r.alert_cleared = clr;
		r.alert_active = alert_f[p];
		r.unfiltered_active = unfilt_f[p];
		return r;
	endfunction

	function automatic dir_row_t mk_row(input logic cmd, input int idx, input logic [31:0] inc,
		input logic [63:0] maxv, input logic [63:0] thr, input logic [5:0] fl, input bit typed,
		input logic [63:0] cnt, input logic [63:0] rep, input logic [3:0] rf);
		dir_row_t row;
		row.cmd = cmd;
		row.it = '0;
		row.it.param_index = IDX_W'(idx);
		row.it.increment = inc;
		row.it.max_value = maxv;
		row.it.threshold = thr;
		{row.it.monitor_valid, row.it.end_of_period, row.it.potential_change,
			row.it.ua_declared, row.it.is_uas_adjusted, row.it.is_uas} = fl;
		row.typed = typed;
		row.want = '0;
		row.want.count_value = cnt;
		row.want.reported_value = rep;
		{row.want.unfiltered_active, row.want.alert_active, row.want.alert_cleared,
			row.want.alert_declared} = rf;
		return row;
	endfunction

	function automatic void draw_item(output item_t it, output logic cmd);
		int          p;
		int          k;
		logic [63:0] base;
		it = '0;
		p = ($urandom_range(99) < 60) ? $urandom_range(7) : $urandom_range(NUM_PARAMS - 1);
		it.param_index = IDX_W'(p);
		base = cnt_mem[p];
		cmd = ($urandom_range(99) < 15) ? CMD_RECHECK : CMD_ACCUM;
		case ($urandom_range(9))
			0, 1, 2, 3: it.max_value = 64'($urandom_range(2000, 1));
			4, 5: it.max_value = ONES;
			6: it.max_value = {$urandom, $urandom};
			7: it.max_value = '0;
			8: it.max_value = base + $urandom_range(40);
			default: it.max_value = {32'h1, $urandom};
		endcase
		case ($urandom_range(7))
			0: it.increment = '0;
			1: it.increment = 32'hFFFF_FFFF;
			2: it.increment = $urandom;
			default: it.increment = $urandom_range(50);
		endcase
		// thresholds mostly near the count so crossings and clears both happen
		case ($urandom_range(7))
			0: it.threshold = '0;
			1: it.threshold = ONES;
			2: it.threshold = {$urandom, $urandom};
			default: it.threshold = base + $urandom_range(80) - 20;
		endcase
		k = ($urandom_range(9) == 0) ? $urandom_range(3) : ptype[p];
		it.is_uas = k[0];
		it.is_uas_adjusted = k[1];
		if ($urandom_range(99) < 12) begin
			link_ua[p] = ~link_ua[p];
		end
		it.ua_declared = link_ua[p];
		it.potential_change = ($urandom_range(99) < 30);
		it.end_of_period = ($urandom_range(99) < 8);
		it.monitor_valid = ($urandom_range(99) < 85);
	endfunction

	task automatic send_word(input item_t it, input logic cmd, input bit typed,
		input result_t want);
		result_t pred;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it;
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		pred = update_entry(it, cmd);
		reports_due.push_back(typed ? want : pred);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_ALL_ALERT_INHIBIT, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		inhibit = v[0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_report(input result_t got);
		result_t e;
		if (reports_due.size() == 0) begin
			if (fails < 10) begin
				$display("unexpected result word: cnt=%h rep=%h", got.count_value,
					got.reported_value);
			end
			fails++;
		end else begin
			e = reports_due.pop_front();
			if (got.count_value !== e.count_value || got.reported_value !== e.reported_value
				|| got.alert_declared !== e.alert_declared
				|| got.alert_cleared !== e.alert_cleared
				|| got.alert_active !== e.alert_active
				|| got.unfiltered_active !== e.unfiltered_active) begin
				if (fails < 10) begin
					$display("mismatch exp cnt=%h rep=%h d/c/a/u=%b%b%b%b", e.count_value,
						e.reported_value, e.alert_declared, e.alert_cleared, e.alert_active,
						e.unfiltered_active);
					$display("         got cnt=%h rep=%h d/c/a/u=%b%b%b%b", got.count_value,
						got.reported_value, got.alert_declared, got.alert_cleared,
						got.alert_active, got.unfiltered_active);
				end
				fails++;
			end
		end
	endtask

	// result side: check at the edge, then pick the next ready
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				check_report(m_tdata);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		int      ph;
		int      n;
		item_t   it;
		logic    c;
		result_t none;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fails = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		inhibit = 1'b0;
		none = '0;
		for (int i = 0; i < NUM_PARAMS; i++) begin
			cnt_mem[i] = '0;
			adj_mem[i] = '0;
			unavail[i] = 1'b0;
			alert_f[i] = 1'b0;
			unfilt_f[i] = 1'b0;
			ptype[i] = i % 4;
			link_ua[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero entries, extremes, saturation at the ceiling, crossing and re-check clear
		dir_rows.push_back(mk_row(CMD_ACCUM, 0, 0, 0, 0, FL_VALID, 1, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_RECHECK, 31, 0, 0, 0, 0, 1, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 1, 32'hFFFF_FFFF, ONES, 0, FL_VALID, 1,
			64'hFFFF_FFFF, 64'hFFFF_FFFF, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 1, 32'hFFFF_FFFF, 64'h1_0000_0000, 64'h1_0000_0000,
			FL_VALID, 1, 64'h1_0000_0000, 64'h1_0000_0000, RS_DECL | RS_ACT | RS_UNF));
		dir_rows.push_back(mk_row(CMD_ACCUM, 1, 32'hFFFF_FFFF, 64'h1_0000_0000, 64'h1_0000_0000,
			FL_VALID, 1, 64'h1_0000_0000, 64'h1_0000_0000, RS_ACT | RS_UNF));
		dir_rows.push_back(mk_row(CMD_RECHECK, 1, 0, 0, ONES, 0, 1,
			64'h1_0000_0000, 64'h1_0000_0000, RS_CLR));
		dir_rows.push_back(mk_row(CMD_RECHECK, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 1, 99, 0, 5, FL_EOP | FL_VALID, 1,
			64'h1_0000_0000, 64'h1_0000_0000, RS_DECL | RS_ACT | RS_UNF));
		// UAS: pending seconds held back, added on entering, taken off on leaving
		dir_rows.push_back(mk_row(CMD_ACCUM, 2, 10, 1000, 5, FL_UAS | FL_PEND | FL_VALID,
			0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 2, 20, 1000, 5, FL_UAS | FL_PEND | FL_VALID,
			0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 2, 5, 1000, 5, FL_UAS | FL_UA | FL_VALID,
			0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 2, 7, 1000, 5,
			FL_UAS | FL_UA | FL_PEND | FL_VALID, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 2, 0, 1000, 5, FL_UAS | FL_VALID, 0, 0, 0, 0));
		// adjusted parameter
		dir_rows.push_back(mk_row(CMD_ACCUM, 3, 50, 1000, 0, FL_ADJ | FL_VALID, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 3, 100, 1000, 0, FL_ADJ | FL_PEND, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 3, 9, 1000, 0, FL_ADJ | FL_UA, 0, 0, 0, 0));
		// subtraction floors at zero when the kind changes under a pending adjustment
		dir_rows.push_back(mk_row(CMD_ACCUM, 5, 100, 1000, 0, FL_UAS | FL_PEND, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 5, 3, 1000, 0, FL_ADJ | FL_UA, 0, 0, 0, 0));
		// both kinds set, adjustment growth capped at a tiny ceiling
		dir_rows.push_back(mk_row(CMD_ACCUM, 6, 32'hFFFF_FFFF, 16, 0,
			FL_UAS | FL_ADJ | FL_PEND, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 6, 0, 16, 16,
			FL_UAS | FL_ADJ | FL_UA | FL_VALID, 0, 0, 0, 0));
		// monitoring off, then on; re-check above the count clears
		dir_rows.push_back(mk_row(CMD_ACCUM, 7, 100, ONES, 1, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 7, 0, ONES, 1, FL_VALID, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_RECHECK, 7, 0, 0, 101, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(CMD_ACCUM, 2, 4, 1000, 1, FL_UAS | FL_PEND | FL_EOP | FL_VALID,
			0, 0, 0, 0));

		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].it, dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
		end

		for (ph = 0; ph < N_PHASES; ph++) begin
			drain();
			reg_write(ph_cfg[ph]);
			idle_pct = ph_sidle[ph];
			stall_pct = ph_rstall[ph];
			if (ph_press[ph]) begin
				hold_left = 300;
			end
			for (n = 0; n < ph_items[ph]; n++) begin
				draw_item(it, c);
				send_word(it, c, 1'b0, none);
			end
		end
		drain();

		if (fails == 0 && reports_due.size() == 0) begin
			$display("pm_counter_uas_adjust_tca regression: pass");
		end else begin
			$display("pm_counter_uas_adjust_tca regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
